/* rtl/core/ckerng_pkg.sv */
// Shared types, constants and functions of the ChaCha20 key erasure generator.
package ckerng_pkg;

  localparam int DEF_CHACHA_ROUNDS = 20;
  localparam int KEY_BYTES         = 32;
  localparam int BUF_BYTES         = 32 + 256;
  localparam int OUT_BYTES         = BUF_BYTES - KEY_BYTES;
  localparam int OUT_WORDS         = OUT_BYTES / 8;
  localparam int OUT_AW            = $clog2(OUT_WORDS);
  localparam int POS_W             = $clog2(OUT_BYTES) + 1;

  localparam logic [2:0] BLK_KEY   = 3'd0;
  localparam logic [2:0] BLK_FIRST = 3'd1;
  localparam logic [2:0] BLK_LAST  = 3'd4;

  localparam logic       REQ_SEED  = 1'b0;
  localparam logic       REQ_DRAW  = 1'b1;
  localparam logic [3:0] MASK_FULL = 4'hF;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  seed_index;
    logic [63:0] seed_word;
    logic [3:0]  byte_count;
  } req_item_t;

  typedef struct packed {
    logic [63:0] random_bytes;
    logic        status;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_READ,
    S_TAKE,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_WRITE,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic       latch;
    logic       ram_read;
    logic       take;
    logic       blk_load;
    logic       round_step;
    logic       add;
    logic       write_word;
    logic       refill_done;
    logic       out_load;
    logic [1:0] step;
    logic       odd;
    logic [2:0] blk;
    logic [2:0] j;
  } ckerng_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic not_seeded;
    logic no_bytes;
    logic empty;
    logic last_take;
  } ckerng_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

/* rtl/core/ckerng_ram.sv */
// Generic simple dual port RAM with registered read.
module ckerng_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ckerng_ctrl.sv */
// Controller state machine for draws, seed loads and buffer refills.
module ckerng_ctrl import ckerng_pkg::*; #(
  parameter int CHACHA_ROUNDS = DEF_CHACHA_ROUNDS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  input  ckerng_stat_t stat,
  output ckerng_cmd_t  cmd
);

  localparam int RND_W = $clog2(CHACHA_ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(CHACHA_ROUNDS - 1);

  ctrl_state_t      state, state_next;
  logic [1:0]       step;
  logic [RND_W-1:0] rnd;
  logic [2:0]       blk;
  logic [2:0]       j;
  logic             out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.is_seed || stat.not_seeded || stat.no_bytes) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = stat.empty ? S_LOAD : S_READ;
      S_READ:   state_next = S_TAKE;
      S_TAKE:   state_next = stat.last_take ? S_FINISH : S_CHECK;
      S_LOAD:   state_next = S_ROUND;
      S_ROUND:  if (step == 2'd3 && rnd == LAST_RND) state_next = S_ADD;
      S_ADD:    state_next = S_WRITE;
      S_WRITE: begin
        if (j == 3'd7) begin
          state_next = (blk == BLK_KEY) ? S_CHECK : S_LOAD;
        end
      end
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.step        = step;
    cmd.odd         = rnd[0];
    cmd.blk         = blk;
    cmd.j           = j;
    cmd.latch       = (state == S_IDLE) && req_valid;
    cmd.ram_read    = (state == S_READ);
    cmd.take        = (state == S_TAKE);
    cmd.blk_load    = (state == S_LOAD);
    cmd.round_step  = (state == S_ROUND);
    cmd.add         = (state == S_ADD);
    cmd.write_word  = (state == S_WRITE);
    cmd.refill_done = (state == S_WRITE) && (j == 3'd7) && (blk == BLK_KEY);
    cmd.out_load    = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      step      <= '0;
      rnd       <= '0;
      blk       <= BLK_FIRST;
      j         <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CHECK: if (stat.empty) blk <= BLK_FIRST;
        S_LOAD: begin
          step <= '0;
          rnd  <= '0;
        end
        S_ROUND: begin
          step <= step + 2'd1;
          if (step == 2'd3) rnd <= rnd + 1'b1;
        end
        S_ADD:   j <= '0;
        S_WRITE: begin
          j <= j + 3'd1;
          if (j == 3'd7 && blk != BLK_KEY) begin
            blk <= (blk == BLK_LAST) ? BLK_KEY : blk + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/ckerng_datapath.sv */
// Datapath: key, ChaCha state, output word store, draw accumulator.
module ckerng_datapath import ckerng_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  req_item_t    req,
  input  ckerng_cmd_t  cmd,
  output ckerng_stat_t stat,
  output rsp_item_t    rsp
);

  logic [31:0]      key [8];
  logic [31:0]      x [16];
  logic [31:0]      x_rnd [16];
  logic [31:0]      in_w [16];
  logic [POS_W-1:0] pos;
  logic [3:0]       mask;
  logic             req_type;
  logic             status;
  logic [3:0]       rem;
  logic [3:0]       k;
  logic [63:0]      acc;
  logic [3:0]       avail;
  logic [3:0]       t;
  logic [63:0]      rd_data;
  logic [63:0]      kept;
  logic [63:0]      shifted;
  logic [5:0]       waddr_full;
  logic             ram_we;
  logic             key_we;
  logic [3:0]       n_sat;

  assign n_sat = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;

  always_comb begin
    in_w[0]  = SIGMA0;
    in_w[1]  = SIGMA1;
    in_w[2]  = SIGMA2;
    in_w[3]  = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      in_w[4 + i] = key[i];
    end
    in_w[12] = {29'd0, cmd.blk};
    in_w[13] = '0;
    in_w[14] = '0;
    in_w[15] = '0;
  end

  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] s;
    for (int i = 0; i < 16; i++) begin
      x_rnd[i] = x[i];
    end
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = cmd.odd ? {2'b01, 2'(q + 1)} : {2'b01, 2'(q)};
      ic = cmd.odd ? {2'b10, 2'(q + 2)} : {2'b10, 2'(q)};
      id = cmd.odd ? {2'b11, 2'(q + 3)} : {2'b11, 2'(q)};
      case (cmd.step)
        2'd0: begin
          s = x[ia] + x[ib];
          x_rnd[ia] = s;
          x_rnd[id] = rotl(x[id] ^ s, 16);
        end
        2'd1: begin
          s = x[ic] + x[id];
          x_rnd[ic] = s;
          x_rnd[ib] = rotl(x[ib] ^ s, 12);
        end
        2'd2: begin
          s = x[ia] + x[ib];
          x_rnd[ia] = s;
          x_rnd[id] = rotl(x[id] ^ s, 8);
        end
        default: begin
          s = x[ic] + x[id];
          x_rnd[ic] = s;
          x_rnd[ib] = rotl(x[ib] ^ s, 7);
        end
      endcase
    end
  end

  assign waddr_full = {cmd.blk, cmd.j} - 6'd4;
  assign key_we = cmd.write_word && (cmd.blk == BLK_KEY) && !cmd.j[2];
  assign ram_we = cmd.write_word && !((cmd.blk == BLK_KEY) && !cmd.j[2])
                  && !((cmd.blk == BLK_LAST) && cmd.j[2]);

  ckerng_ram #(
    .WIDTH(64),
    .DEPTH(OUT_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_full[OUT_AW-1:0]),
    .wdata({x[{cmd.j, 1'b1}], x[{cmd.j, 1'b0}]}),
    .re   (cmd.ram_read),
    .raddr(pos[OUT_AW+2:3]),
    .rdata(rd_data)
  );

  assign avail = 4'd8 - {1'b0, pos[2:0]};
  assign t     = (rem < avail) ? rem : avail;

  always_comb begin
    shifted = rd_data >> {pos[2:0], 3'b000};
    for (int b = 0; b < 8; b++) begin
      kept[8*b +: 8] = (4'(b) < t) ? shifted[8*b +: 8] : 8'd0;
    end
  end

  assign stat.is_seed    = (req_type == REQ_SEED);
  assign stat.not_seeded = status;
  assign stat.no_bytes   = (rem == 4'd0);
  assign stat.empty      = pos[POS_W-1];
  assign stat.last_take  = (rem <= avail);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_W'(OUT_BYTES);
      mask <= '0;
    end else begin
      if (cmd.latch && req.req_type == REQ_SEED) begin
        mask[req.seed_index] <= 1'b1;
        pos                  <= POS_W'(OUT_BYTES);
      end else if (cmd.take) begin
        pos <= pos + POS_W'(t);
      end else if (cmd.refill_done) begin
        pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type <= req.req_type;
      status   <= (req.req_type == REQ_DRAW) && (mask != MASK_FULL);
      rem      <= n_sat;
      k        <= '0;
      acc      <= '0;
      if (req.req_type == REQ_SEED) begin
        key[{req.seed_index, 1'b0}] <= req.seed_word[31:0];
        key[{req.seed_index, 1'b1}] <= req.seed_word[63:32];
      end
    end
    if (cmd.take) begin
      acc <= acc | (kept << {k[2:0], 3'b000});
      k   <= k + t;
      rem <= rem - t;
    end
    if (key_we) begin
      key[{cmd.j[1:0], 1'b0}] <= x[{cmd.j, 1'b0}];
      key[{cmd.j[1:0], 1'b1}] <= x[{cmd.j, 1'b1}];
    end
    if (cmd.blk_load) begin
      for (int i = 0; i < 16; i++) begin
        x[i] <= in_w[i];
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < 16; i++) begin
        x[i] <= x_rnd[i];
      end
    end else if (cmd.add) begin
      for (int i = 0; i < 16; i++) begin
        x[i] <= x[i] + in_w[i];
      end
    end
    if (cmd.out_load) begin
      rsp.random_bytes <= acc;
      rsp.status       <= status;
    end
  end

endmodule

/* rtl/core/chacha20_key_erasure_rng.sv */
// Top level of the ChaCha20 key erasure random byte generator.
// Seed load, zero-byte or unseeded draw: result registered through the decode and finish states.
// Draw from a filled buffer: check, read and take once per stored word spanned, then finish.
// Refill: 5 blocks, each loaded, run through the rounds by the single quarter-round
// step unit, added and written; one item in flight, next item taken while a result waits.
// Reset clears the seed mask and marks the buffer empty; key and buffer are undefined.
module chacha20_key_erasure_rng import ckerng_pkg::*; #(
  parameter int CHACHA_ROUNDS = DEF_CHACHA_ROUNDS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  ckerng_cmd_t  cmd;
  ckerng_stat_t stat;

  ckerng_ctrl #(
    .CHACHA_ROUNDS(CHACHA_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ckerng_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule

/* tb/sv/tb_chacha20_key_erasure_rng.sv */
// Testbench for the ChaCha20 key erasure random byte generator.
`timescale 1ns / 100ps

class rng_scoreboard;
  logic [7:0]            pool [ckerng_pkg::BUF_BYTES];
  logic [31:0]           x [16];
  int unsigned           rd_pos;
  logic [3:0]            seeded;
  int unsigned           rounds;
  int unsigned           errors;
  int unsigned           checked;
  ckerng_pkg::rsp_item_t exp_q [$];

  function new(int unsigned n_rounds);
    rounds  = n_rounds;
    rd_pos  = ckerng_pkg::BUF_BYTES;
    seeded  = '0;
    errors  = 0;
    checked = 0;
    foreach (pool[i]) pool[i] = 8'd0;
  endfunction

  function void quarter(int a, int b, int c, int d);
    x[a] = x[a] + x[b]; x[d] = ckerng_pkg::rotl(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = ckerng_pkg::rotl(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = ckerng_pkg::rotl(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = ckerng_pkg::rotl(x[b] ^ x[c], 7);
  endfunction

  function void refill();
    logic [31:0] key_w [8];
    logic [31:0] in_w [16];
    logic [31:0] w;
    int          pos;
    for (int i = 0; i < 8; i++) begin
      key_w[i] = {pool[4*i+3], pool[4*i+2], pool[4*i+1], pool[4*i]};
    end
    for (int blk = 0; blk < 5; blk++) begin
      in_w[0] = ckerng_pkg::SIGMA0;
      in_w[1] = ckerng_pkg::SIGMA1;
      in_w[2] = ckerng_pkg::SIGMA2;
      in_w[3] = ckerng_pkg::SIGMA3;
      for (int i = 0; i < 8; i++) in_w[4 + i] = key_w[i];
      in_w[12] = 32'(blk);
      in_w[13] = '0;
      in_w[14] = '0;
      in_w[15] = '0;
      for (int i = 0; i < 16; i++) x[i] = in_w[i];
      for (int r = 0; r < int'(rounds); r++) begin
        if ((r & 1) == 0) begin
          quarter(0, 4, 8, 12);
          quarter(1, 5, 9, 13);
          quarter(2, 6, 10, 14);
          quarter(3, 7, 11, 15);
        end else begin
          quarter(0, 5, 10, 15);
          quarter(1, 6, 11, 12);
          quarter(2, 7, 8, 13);
          quarter(3, 4, 9, 14);
        end
      end
      for (int i = 0; i < 64; i++) begin
        pos = blk * 64 + i;
        w   = x[i >> 2] + in_w[i >> 2];
        if (pos < ckerng_pkg::BUF_BYTES) pool[pos] = w[8*(i & 3) +: 8];
      end
    end
    rd_pos = ckerng_pkg::KEY_BYTES;
  endfunction

  function void note_input(ckerng_pkg::req_item_t r);
    ckerng_pkg::rsp_item_t e;
    int                    n;
    e = '0;
    if (r.req_type == ckerng_pkg::REQ_SEED) begin
      for (int b = 0; b < 8; b++) begin
        pool[int'(r.seed_index) * 8 + b] = r.seed_word[8*b +: 8];
      end
      seeded[r.seed_index] = 1'b1;
      rd_pos = ckerng_pkg::BUF_BYTES;
    end else if (seeded != ckerng_pkg::MASK_FULL) begin
      e.status = 1'b1;
    end else begin
      n = (r.byte_count > ckerng_pkg::MAX_BYTES) ? 8 : int'(r.byte_count);
      for (int k = 0; k < n; k++) begin
        if (rd_pos >= ckerng_pkg::BUF_BYTES) refill();
        e.random_bytes[8*k +: 8] = pool[rd_pos];
        rd_pos++;
      end
    end
    exp_q.push_back(e);
  endfunction

  function void check_result(ckerng_pkg::rsp_item_t a);
    ckerng_pkg::rsp_item_t e;
    if (exp_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch %0d: no item expected, actual %h status %0d",
                 errors, a.random_bytes, a.status);
      end
      return;
    end
    e = exp_q.pop_front();
    checked++;
    if (a !== e) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch %0d: expected %h status %0d, actual %h status %0d",
                 errors, e.random_bytes, e.status, a.random_bytes, a.status);
      end
    end
  endfunction

  function int unsigned pending();
    return exp_q.size();
  endfunction
endclass

module tb_chacha20_key_erasure_rng import ckerng_pkg::*; ();

  localparam int N_ITEMS    = 1600;
  localparam int MAX_CYCLES = 1000000;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  req_item_t     req;
  logic          rsp_valid;
  logic          rsp_stall;
  rsp_item_t     rsp;
  rng_scoreboard sb;
  int unsigned   cycles = 0;
  int unsigned   sent = 0;
  int            send_idle = 0;
  int            recv_idle = 0;

  chacha20_key_erasure_rng #(
    .CHACHA_ROUNDS(DEF_CHACHA_ROUNDS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_input(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    end
  end

  function automatic req_item_t seed_item(input logic [1:0] idx);
    req_item_t r;
    r.req_type   = REQ_SEED;
    r.seed_index = idx;
    r.seed_word  = {$urandom, $urandom};
    r.byte_count = 4'($urandom);
    return r;
  endfunction

  function automatic req_item_t draw_item();
    req_item_t   r;
    int unsigned sel;
    sel          = $urandom_range(99);
    r.req_type   = REQ_DRAW;
    r.seed_index = 2'($urandom);
    r.seed_word  = {$urandom, $urandom};
    if (sel < 5) begin
      r.byte_count = 4'd0;
    end else if (sel < 12) begin
      r.byte_count = 4'($urandom_range(15, 9));
    end else if (sel < 40) begin
      r.byte_count = MAX_BYTES;
    end else begin
      r.byte_count = 4'($urandom_range(8, 1));
    end
    return r;
  endfunction

  task automatic send_item(input req_item_t item);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new(DEF_CHACHA_ROUNDS);
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    send_idle = 37;
    recv_idle = 55;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(draw_item());
    for (int i = 0; i < 3; i++) send_item(seed_item(2'(i)));
    send_item(draw_item());
    send_item(seed_item(2'd3));

    while (sent < N_ITEMS) begin
      if (sent == N_ITEMS / 3) begin
        wait_drain();
        send_idle = 55;
        recv_idle = 37;
      end
      if (sent == 2 * N_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(99) < 2) begin
        send_item(seed_item(2'($urandom)));
      end else begin
        send_item(draw_item());
      end
    end
    wait_drain();

    if (sb.errors == 0 && sb.checked == sent) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ckerng_pkg.sv
rtl/core/ckerng_ram.sv
rtl/core/ckerng_ctrl.sv
rtl/core/ckerng_datapath.sv
rtl/core/chacha20_key_erasure_rng.sv
tb/sv/tb_chacha20_key_erasure_rng.sv
